[hw/rtl/jds_pkg.sv]
package jds_pkg;

    // Config register indexes
    localparam logic [2:0] REG_CENTER_X  = 3'd0;
    localparam logic [2:0] REG_CENTER_Y  = 3'd1;
    localparam logic [2:0] REG_DEADZONE  = 3'd2;
    localparam logic [2:0] REG_OPTIONS   = 3'd3;
    localparam logic [2:0] REG_SPEED_MOD = 3'd4;
    localparam logic [2:0] REG_TURN_MODE = 3'd5;
    localparam logic [2:0] REG_RAMP_RATE = 3'd6;

    // Turn modes
    localparam logic [1:0] TURN_OFF     = 2'd0;
    localparam logic [1:0] TURN_HALF    = 2'd1;
    localparam logic [1:0] TURN_QUARTER = 2'd2;
    localparam logic [1:0] TURN_SPEED   = 2'd3;

    // Option flag bits
    localparam int OPT_INV_SPEED = 0;
    localparam int OPT_INV_STEER = 1;
    localparam int OPT_CURVE     = 2;

    localparam logic [14:0] FULL_Q8  = 15'd25600;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Shared divider widths
    localparam int DIV_NW = 27;
    localparam int DIV_DW = 16;

    // Division by 100 and by 200 as (x * M) >> S, exact for the operand
    // ranges used: below 2^22 for the limit and below 2^15 for the turn.
    localparam logic [22:0] RECIP_100 = 23'd5368710;
    localparam int          SHIFT_100 = 29;
    localparam logic [15:0] RECIP_200 = 16'd41944;
    localparam int          SHIFT_200 = 23;

    typedef struct packed {
        logic load_in;
        logic prep;
        logic store_p;
        logic curv0;
        logic curv1;
        logic cmul;
        logic ccmp;
        logic lim;
        logic store_lim;
        logic round;
        logic store_turn;
        logic fin;
        logic crc_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic curve_on;
        logic turn_div;
        logic div_busy;
        logic bit_last;
        logic axis_y;
        logic send;
        logic crc_last;
        logic out_free;
    } t_sts;

    function automatic logic [6:0] limit_pct(input logic [1:0] mode);
        case (mode)
            2'd0:    limit_pct = 7'd100;
            2'd1:    limit_pct = 7'd60;
            default: limit_pct = 7'd30;
        endcase
    endfunction

    function automatic logic [3:0] ramp_step(input logic [1:0] rate);
        case (rate)
            2'd1:    ramp_step = 4'd10;
            2'd2:    ramp_step = 4'd5;
            2'd3:    ramp_step = 4'd2;
            default: ramp_step = 4'd0;
        endcase
    endfunction

endpackage

[hw/rtl/jds_div.sv]
module jds_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [jds_pkg::DIV_NW-1:0]  i_num,
    input  logic [jds_pkg::DIV_DW-1:0]  i_den,
    output logic                        o_busy,
    output logic [jds_pkg::DIV_NW-1:0]  o_quot
);

    logic                        r_busy;
    logic [4:0]                  r_cnt;
    logic [jds_pkg::DIV_DW-1:0]  r_rem;
    logic [jds_pkg::DIV_NW-1:0]  r_q;
    logic [jds_pkg::DIV_DW-1:0]  r_den;
    logic [jds_pkg::DIV_DW:0]    sh;
    logic [jds_pkg::DIV_DW:0]    diff;
    logic                        qbit;

    // One restoring step per cycle, quotient bits enter from the right.
    assign sh   = {r_rem, r_q[jds_pkg::DIV_NW-1]};
    assign diff = sh - {1'b0, r_den};
    assign qbit = (sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'(jds_pkg::DIV_NW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[jds_pkg::DIV_DW-1:0] : sh[jds_pkg::DIV_DW-1:0];
            r_q   <= {r_q[jds_pkg::DIV_NW-2:0], qbit};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

[hw/rtl/jds_dp.sv]
module jds_dp #(
    parameter int ADC_FULL_SCALE = 4095
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jds_pkg::t_cmd      i_cmd,
    output jds_pkg::t_sts      o_sts,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [11:0]        i_cfg_data,
    input  logic [11:0]        i_raw_x,
    input  logic [11:0]        i_raw_y,
    input  logic               i_send_now,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [7:0]  o_speed,
    output logic signed [7:0]  o_steer,
    output logic               o_sent,
    output logic [2:0]         o_packet_flags,
    output logic [7:0]         o_sequence_res,
    output logic [15:0]        o_packet_crc
);

    localparam logic signed [17:0] HALF = 18'(ADC_FULL_SCALE / 2);

    // Configuration
    logic [11:0] r_cx, r_cy;
    logic [10:0] r_dz;
    logic [2:0]  r_opt;
    logic [1:0]  r_smode, r_tmode, r_ramp;

    // Item and work registers
    logic [11:0] r_raw_x, r_raw_y;
    logic        r_send, r_axis;
    logic        r_neg;
    logic [14:0] r_p, r_q;
    logic [29:0] r_pp;
    logic [44:0] r_v;
    logic [31:0] r_tt;
    logic [3:0]  r_bit;
    logic [14:0] r_mx, r_my;
    logic        r_nx, r_ny;
    logic signed [7:0] r_spd;
    logic [6:0]  r_sm;
    logic        r_sn;
    logic signed [7:0] r_fs, r_ft;
    logic [15:0] r_crc;
    logic [47:0] r_sh;
    logic [5:0]  r_cnt;
    logic [21:0] r_ln;
    logic [14:0] r_tn;

    // Packet state
    logic signed [7:0] r_last_s, r_last_t;
    logic [7:0]  r_seq;

    // Output register
    logic        r_ov;
    logic signed [7:0] r_os, r_ot;
    logic        r_osent;
    logic [2:0]  r_oflags;
    logic [7:0]  r_oseq;
    logic [15:0] r_ocrc;

    // Axis front end
    logic [11:0] sample, ctr;
    logic signed [12:0] d;
    logic [11:0] mag;
    logic        zero, sat;
    logic signed [17:0] span;

    // Divider
    logic                        div_start, div_busy;
    logic [jds_pkg::DIV_NW-1:0]  div_num, div_quot;
    logic [jds_pkg::DIV_DW-1:0]  div_den;

    // Constant divisions
    logic [44:0] lim_prod;
    logic [30:0] turn_prod;

    // Curve search
    logic [14:0] cand;
    logic [15:0] tcur;
    logic [45:0] tt_sc;

    // Rounding and turn
    logic [6:0]  rx, ry;
    logic [7:0]  ry_h;
    logic [8:0]  ry_q;
    logic [7:0]  turn_fac;

    // Final shaping
    logic signed [9:0] s_tgt, t_tgt, s_out, t_out;
    logic signed [9:0] stp;
    logic        fb;

    assign sample = r_axis ? r_raw_y : r_raw_x;
    assign ctr    = r_axis ? r_cy : r_cx;
    assign d      = $signed({1'b0, sample}) - $signed({1'b0, ctr});
    assign mag    = d[12] ? 12'(-d) : d[11:0];
    assign zero   = ({1'b0, mag} <= {2'b0, r_dz});
    assign span   = HALF - $signed({7'b0, r_dz});
    assign sat    = (span <= 18'sd0) || ($signed({6'b0, mag}) >= span);

    assign cand  = r_q | (15'd1 << r_bit);
    assign tcur  = {cand, 1'b0} - 16'd1;
    // 6400 = 4096 + 2048 + 256
    assign tt_sc = ({14'b0, r_tt} << 12) + ({14'b0, r_tt} << 11) + ({14'b0, r_tt} << 8);

    assign rx       = 7'(({1'b0, r_mx} + 16'd128) >> 8);
    assign ry       = 7'(({1'b0, r_my} + 16'd128) >> 8);
    assign ry_h     = ({1'b0, ry} + 8'd1) >> 1;
    assign ry_q     = ({2'b0, ry} + 9'd2) >> 2;
    assign turn_fac = 8'd200 - {1'b0, rx};

    assign lim_prod  = r_ln * jds_pkg::RECIP_100;
    assign turn_prod = r_tn * jds_pkg::RECIP_200;

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        if (i_cmd.prep && !zero && !sat) begin
            div_start = 1'b1;
            div_num   = 27'({15'b0, mag} * 27'd25600) + 27'(span[15:1]);
            div_den   = span[15:0];
        end
    end

    jds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    always_comb begin
        s_tgt = {{2{r_spd[7]}}, r_spd};
        if (r_opt[jds_pkg::OPT_INV_SPEED]) s_tgt = -s_tgt;
        t_tgt = r_sn ? -$signed({3'b0, r_sm}) : $signed({3'b0, r_sm});
        if (r_opt[jds_pkg::OPT_INV_STEER]) t_tgt = -t_tgt;
        stp   = $signed({6'b0, jds_pkg::ramp_step(r_ramp)});
        s_out = s_tgt;
        t_out = t_tgt;
        if (r_ramp != 2'd0) begin
            if (s_tgt > $signed({{2{r_last_s[7]}}, r_last_s}) + stp)
                s_out = $signed({{2{r_last_s[7]}}, r_last_s}) + stp;
            else if (s_tgt < $signed({{2{r_last_s[7]}}, r_last_s}) - stp)
                s_out = $signed({{2{r_last_s[7]}}, r_last_s}) - stp;
            if (t_tgt > $signed({{2{r_last_t[7]}}, r_last_t}) + stp)
                t_out = $signed({{2{r_last_t[7]}}, r_last_t}) + stp;
            else if (t_tgt < $signed({{2{r_last_t[7]}}, r_last_t}) - stp)
                t_out = $signed({{2{r_last_t[7]}}, r_last_t}) - stp;
        end
    end

    assign fb = r_crc[15] ^ r_sh[47];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= 12'd2048;
            r_cy    <= 12'd2048;
            r_dz    <= 11'd180;
            r_opt   <= 3'd4;
            r_smode <= 2'd0;
            r_tmode <= 2'd0;
            r_ramp  <= 2'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                jds_pkg::REG_CENTER_X:  r_cx    <= i_cfg_data;
                jds_pkg::REG_CENTER_Y:  r_cy    <= i_cfg_data;
                jds_pkg::REG_DEADZONE:  r_dz    <= i_cfg_data[10:0];
                jds_pkg::REG_OPTIONS:   r_opt   <= i_cfg_data[2:0];
                jds_pkg::REG_SPEED_MOD: r_smode <= i_cfg_data[1:0];
                jds_pkg::REG_TURN_MODE: r_tmode <= i_cfg_data[1:0];
                jds_pkg::REG_RAMP_RATE: r_ramp  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_raw_x <= i_raw_x;
            r_raw_y <= i_raw_y;
            r_send  <= i_send_now;
        end
        if (i_cmd.prep) begin
            r_neg <= d[12];
            if (zero)     r_p <= '0;
            else if (sat) r_p <= jds_pkg::FULL_Q8;
        end
        if (i_cmd.store_p) begin
            r_p <= (div_quot > 27'(jds_pkg::FULL_Q8)) ? jds_pkg::FULL_Q8 : div_quot[14:0];
        end
        if (i_cmd.curv0) begin
            r_pp <= r_p * r_p;
            r_q  <= r_opt[jds_pkg::OPT_CURVE] ? 15'd0 : r_p;
        end
        if (i_cmd.curv1) begin
            r_v   <= r_pp * r_p;
            r_bit <= 4'd14;
        end
        if (i_cmd.cmul) begin
            r_tt <= tcur * tcur;
        end
        if (i_cmd.ccmp) begin
            if (tt_sc <= {1'b0, r_v}) r_q <= cand;
            r_bit <= r_bit - 4'd1;
        end
        if (i_cmd.lim) begin
            r_ln <= {7'b0, r_q} * {15'b0, jds_pkg::limit_pct(r_smode)} + 22'd50;
        end
        if (i_cmd.store_lim) begin
            if (r_axis) begin
                r_my <= lim_prod[jds_pkg::SHIFT_100+14:jds_pkg::SHIFT_100];
                r_ny <= r_neg;
            end else begin
                r_mx <= lim_prod[jds_pkg::SHIFT_100+14:jds_pkg::SHIFT_100];
                r_nx <= r_neg;
            end
        end
        if (i_cmd.round) begin
            // Speed is the negated X axis.
            r_spd <= r_nx ? $signed({1'b0, rx}) : -$signed({1'b0, rx});
            r_sn  <= r_ny;
            r_tn  <= {8'b0, ry} * {7'b0, turn_fac} + 15'd100;
            case (r_tmode)
                jds_pkg::TURN_HALF:    r_sm <= ry_h[6:0];
                jds_pkg::TURN_QUARTER: r_sm <= ry_q[6:0];
                default:               r_sm <= ry;
            endcase
        end
        if (i_cmd.store_turn) begin
            r_sm <= turn_prod[jds_pkg::SHIFT_200+6:jds_pkg::SHIFT_200];
        end
        if (i_cmd.fin) begin
            r_fs  <= s_out[7:0];
            r_ft  <= t_out[7:0];
            r_crc <= jds_pkg::CRC_INIT;
            r_cnt <= '0;
            r_sh  <= {s_out[7:0], {8{s_out[7]}}, t_out[7:0], {8{t_out[7]}},
                      5'b0, r_opt, r_seq};
        end
        if (i_cmd.crc_step) begin
            r_crc <= {r_crc[14:0], 1'b0} ^ (fb ? jds_pkg::CRC_POLY : 16'h0000);
            r_sh  <= {r_sh[46:0], 1'b0};
            r_cnt <= r_cnt + 6'd1;
        end
        if (i_cmd.out_load) begin
            r_os     <= r_fs;
            r_ot     <= r_ft;
            r_osent  <= r_send;
            r_oflags <= r_send ? r_opt : 3'd0;
            r_oseq   <= r_send ? r_seq : 8'd0;
            r_ocrc   <= r_send ? r_crc : 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis   <= 1'b0;
            r_ov     <= 1'b0;
            r_last_s <= '0;
            r_last_t <= '0;
            r_seq    <= '0;
        end else begin
            if (i_cmd.load_in) begin
                r_axis <= 1'b0;
            end else if (i_cmd.store_lim) begin
                r_axis <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
                if (r_send) begin
                    r_last_s <= r_fs;
                    r_last_t <= r_ft;
                    r_seq    <= r_seq + 8'd1;
                end
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_sts.need_div = !zero && !sat;
    assign o_sts.curve_on = r_opt[jds_pkg::OPT_CURVE];
    assign o_sts.turn_div = (r_tmode == jds_pkg::TURN_SPEED);
    assign o_sts.div_busy = div_busy;
    assign o_sts.bit_last = (r_bit == 4'd0);
    assign o_sts.axis_y   = r_axis;
    assign o_sts.send     = r_send;
    assign o_sts.crc_last = (r_cnt == 6'd47);
    assign o_sts.out_free = !r_ov || !i_out_stall;

    assign o_out_valid    = r_ov;
    assign o_speed        = r_os;
    assign o_steer        = r_ot;
    assign o_sent         = r_osent;
    assign o_packet_flags = r_oflags;
    assign o_sequence_res = r_oseq;
    assign o_packet_crc   = r_ocrc;

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_os >= -8'sd100 && r_os <= 8'sd100))
        else $error("speed out of range");

    a_steer_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_ot >= -8'sd100 && r_ot <= 8'sd100))
        else $error("steer out of range");

    a_no_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_osent) |-> (r_ocrc == 16'd0 && r_oseq == 8'd0 && r_oflags == 3'd0))
        else $error("packet fields set without a send");

    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && r_send) |=> (r_seq == $past(r_seq) + 8'd1))
        else $error("sequence did not advance");

endmodule

[hw/rtl/jds_ctrl.sv]
module jds_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  jds_pkg::t_sts  i_sts,
    output jds_pkg::t_cmd  o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_PREP  = 14'b00000000000010,
        S_DIVP  = 14'b00000000000100,
        S_CURV0 = 14'b00000000001000,
        S_CURV1 = 14'b00000000010000,
        S_CMUL  = 14'b00000000100000,
        S_CCMP  = 14'b00000001000000,
        S_LIM   = 14'b00000010000000,
        S_DIVL  = 14'b00000100000000,
        S_ROUND = 14'b00001000000000,
        S_DIVT  = 14'b00010000000000,
        S_FIN   = 14'b00100000000000,
        S_CRC   = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = i_sts.need_div ? S_DIVP : S_CURV0;
            end
            S_DIVP: begin
                if (!i_sts.div_busy) begin
                    o_cmd.store_p = 1'b1;
                    n_state = S_CURV0;
                end
            end
            S_CURV0: begin
                o_cmd.curv0 = 1'b1;
                n_state = i_sts.curve_on ? S_CURV1 : S_LIM;
            end
            S_CURV1: begin
                o_cmd.curv1 = 1'b1;
                n_state = S_CMUL;
            end
            S_CMUL: begin
                o_cmd.cmul = 1'b1;
                n_state = S_CCMP;
            end
            S_CCMP: begin
                o_cmd.ccmp = 1'b1;
                n_state = i_sts.bit_last ? S_LIM : S_CMUL;
            end
            S_LIM: begin
                o_cmd.lim = 1'b1;
                n_state = S_DIVL;
            end
            S_DIVL: begin
                if (!i_sts.div_busy) begin
                    o_cmd.store_lim = 1'b1;
                    n_state = i_sts.axis_y ? S_ROUND : S_PREP;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state = i_sts.turn_div ? S_DIVT : S_FIN;
            end
            S_DIVT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.store_turn = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = i_sts.send ? S_CRC : S_OUT;
            end
            S_CRC: begin
                o_cmd.crc_step = 1'b1;
                if (i_sts.crc_last) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.store_p || o_cmd.store_lim || o_cmd.store_turn) |-> !i_sts.div_busy)
        else $error("divider result taken while busy");

    a_out_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !i_sts.out_free) |=> r_state == S_OUT)
        else $error("result dropped while output full");

    a_axis_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> i_sts.axis_y)
        else $error("rounding before both axes done");

endmodule

[hw/rtl/joystick_drive_shaper.sv]
// Channel   Valid         Stall         Payload
// input     i_in_valid    o_in_stall    i_raw_x, i_raw_y, i_send_now
// output    o_out_valid   i_out_stall   o_speed, o_steer, o_sent, o_packet_flags,
//                                       o_sequence_res, o_packet_crc
// config    i_cfg_we      (none)        i_cfg_index, i_cfg_data
//
// One item is worked at a time. Each axis runs the 27-step span divider when the
// sample lies between the deadzone and full scale, and the 15-step curve search
// when the curve option is set; the bit-serial CRC over 48 packet bits runs only
// for items that are sent.
// Reset is synchronous and active low; it restores the registers to defaults
// and clears the ramp values and sequence number.
// A finished result waits in the output register while the next item is taken;
// a stalled output holds the controller until the register is free.
module joystick_drive_shaper #(
    parameter int ADC_FULL_SCALE = 4095
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [11:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [11:0]        i_raw_x,
    input  logic [11:0]        i_raw_y,
    input  logic               i_send_now,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [7:0]  o_speed,
    output logic signed [7:0]  o_steer,
    output logic               o_sent,
    output logic [2:0]         o_packet_flags,
    output logic [7:0]         o_sequence_res,
    output logic [15:0]        o_packet_crc
);

    jds_pkg::t_cmd cmd;
    jds_pkg::t_sts sts;

    jds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    jds_dp #(
        .ADC_FULL_SCALE (ADC_FULL_SCALE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_raw_x        (i_raw_x),
        .i_raw_y        (i_raw_y),
        .i_send_now     (i_send_now),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_speed        (o_speed),
        .o_steer        (o_steer),
        .o_sent         (o_sent),
        .o_packet_flags (o_packet_flags),
        .o_sequence_res (o_sequence_res),
        .o_packet_crc   (o_packet_crc)
    );

endmodule

[tb/joystick_drive_shaper_checker.sv]
`timescale 1ns / 1ps

module joystick_drive_shaper_checker #(
    parameter int ADC_FULL_SCALE = 4095
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [11:0]       i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [11:0]       i_raw_x,
    input  logic [11:0]       i_raw_y,
    input  logic              i_send_now,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic signed [7:0] i_speed,
    input  logic signed [7:0] i_steer,
    input  logic              i_sent,
    input  logic [2:0]        i_packet_flags,
    input  logic [7:0]        i_sequence_res,
    input  logic [15:0]       i_packet_crc,
    output int                o_errors,
    output int                o_pending
);

    typedef struct {
        logic signed [7:0] speed;
        logic signed [7:0] steer;
        logic              sent;
        logic [2:0]        flags;
        logic [7:0]        seq;
        logic [15:0]       crc;
    } t_drive_cmd;

    t_drive_cmd expected_cmds[$];

    // Shadow copy of the registers and of the ramp and sequence state.
    logic [11:0] cen_x, cen_y;
    logic [10:0] dead;
    logic [2:0]  opts;
    logic [1:0]  spd_mode, trn_mode, rate;
    int          prev_speed, prev_steer;
    logic [7:0]  seq_next;

    function automatic int curve_q8(int p);
        longint cube = longint'(p) * p * p;
        longint lo = 0, hi = 25600, mid, t;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = 2 * mid - 1;
            if (t * t * 6400 <= cube) lo = mid;
            else hi = mid - 1;
        end
        return int'(lo);
    endfunction

    function automatic int limit_of(logic [1:0] m);
        case (m)
            2'd0:    return 100;
            2'd1:    return 60;
            default: return 30;
        endcase
    endfunction

    function automatic int shape_q8(int raw, int centre);
        int d = raw - centre;
        int mag = d < 0 ? -d : d;
        int span = ADC_FULL_SCALE / 2 - int'(dead);
        longint q;
        int p;
        if (mag <= int'(dead)) return 0;
        if (span <= 0) begin
            p = 25600;
        end else begin
            q = (longint'(mag) * 25600 + span / 2) / span;
            p = q > 25600 ? 25600 : int'(q);
        end
        if (opts[jds_pkg::OPT_CURVE]) p = curve_q8(p);
        p = (p * limit_of(spd_mode) + 50) / 100;
        return d < 0 ? -p : p;
    endfunction

    function automatic int round_pct(int q);
        int r = ((q < 0 ? -q : q) + 128) >>> 8;
        return q < 0 ? -r : r;
    endfunction

    function automatic int scaled(int v, int num, int den);
        int r = ((v < 0 ? -v : v) * num + den / 2) / den;
        return v < 0 ? -r : r;
    endfunction

    function automatic int ramped(int target, int last, int stp);
        if (target > last + stp) return last + stp;
        if (target < last - stp) return last - stp;
        return target;
    endfunction

    function automatic logic [15:0] crc_add(logic [15:0] crc, logic [7:0] b);
        crc ^= {b, 8'h00};
        for (int i = 0; i < 8; i++)
            crc = crc[15] ? ((crc << 1) ^ jds_pkg::CRC_POLY) : (crc << 1);
        return crc;
    endfunction

    function automatic t_drive_cmd shape_sample(int rx, int ry, logic snd);
        t_drive_cmd c;
        int sp, st, stp;
        logic [15:0] su, tu;
        sp = -round_pct(shape_q8(rx, cen_x));
        st = round_pct(shape_q8(ry, cen_y));
        case (trn_mode)
            jds_pkg::TURN_HALF:    st = scaled(st, 1, 2);
            jds_pkg::TURN_QUARTER: st = scaled(st, 1, 4);
            jds_pkg::TURN_SPEED:   st = scaled(st, 200 - (sp < 0 ? -sp : sp), 200);
            default: ;
        endcase
        if (opts[jds_pkg::OPT_INV_SPEED]) sp = -sp;
        if (opts[jds_pkg::OPT_INV_STEER]) st = -st;
        if (rate != 2'd0) begin
            stp = rate == 2'd1 ? 10 : (rate == 2'd2 ? 5 : 2);
            sp = ramped(sp, prev_speed, stp);
            st = ramped(st, prev_steer, stp);
        end
        c.speed = sp[7:0];
        c.steer = st[7:0];
        c.sent  = snd;
        c.flags = '0;
        c.seq   = '0;
        c.crc   = '0;
        if (snd) begin
            su = sp[15:0];
            tu = st[15:0];
            c.flags = opts;
            c.seq   = seq_next;
            c.crc   = crc_add(crc_add(crc_add(crc_add(crc_add(crc_add(jds_pkg::CRC_INIT,
                      su[7:0]), su[15:8]), tu[7:0]), tu[15:8]), {5'd0, opts}), seq_next);
            seq_next   = seq_next + 8'd1;
            prev_speed = sp;
            prev_steer = st;
        end
        return c;
    endfunction

    task automatic report(string field, int got, int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
        o_errors++;
    endtask

    assign o_pending = expected_cmds.size();

    always @(posedge i_clk) begin
        t_drive_cmd want;
        if (!i_rst_n) begin
            cen_x = 12'd2048; cen_y = 12'd2048; dead = 11'd180; opts = 3'd4;
            spd_mode = 2'd0; trn_mode = jds_pkg::TURN_OFF; rate = 2'd0;
            prev_speed = 0; prev_steer = 0; seq_next = 8'd0;
            expected_cmds.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    jds_pkg::REG_CENTER_X:  cen_x = i_cfg_data;
                    jds_pkg::REG_CENTER_Y:  cen_y = i_cfg_data;
                    jds_pkg::REG_DEADZONE:  dead = i_cfg_data[10:0];
                    jds_pkg::REG_OPTIONS:   opts = i_cfg_data[2:0];
                    jds_pkg::REG_SPEED_MOD: spd_mode = i_cfg_data[1:0];
                    jds_pkg::REG_TURN_MODE: trn_mode = i_cfg_data[1:0];
                    jds_pkg::REG_RAMP_RATE: rate = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_cmds.push_back(shape_sample(i_raw_x, i_raw_y, i_send_now));
            if (i_out_valid && !i_out_stall) begin
                if (expected_cmds.size() == 0) begin
                    $display("%0t: result arrived with nothing expected", $time);
                    o_errors++;
                end else begin
                    want = expected_cmds.pop_front();
                    if (i_speed !== want.speed) report("speed", i_speed, want.speed);
                    if (i_steer !== want.steer) report("steer", i_steer, want.steer);
                    if (i_sent !== want.sent) report("sent", i_sent, want.sent);
                    if (i_packet_flags !== want.flags)
                        report("packet_flags", i_packet_flags, want.flags);
                    if (i_sequence_res !== want.seq)
                        report("sequence_res", i_sequence_res, want.seq);
                    if (i_packet_crc !== want.crc)
                        report("packet_crc", i_packet_crc, want.crc);
                end
            end
        end
    end

endmodule

[tb/joystick_drive_shaper_tb.sv]
`timescale 1ns / 1ps

module joystick_drive_shaper_tb;

    localparam int SETTLE     = 300;
    localparam int STALL_LIMIT = 6000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [2:0]        i_cfg_index = '0;
    logic [11:0]       i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [11:0]       i_raw_x = '0;
    logic [11:0]       i_raw_y = '0;
    logic              i_send_now = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic signed [7:0] o_speed, o_steer;
    logic              o_sent;
    logic [2:0]        o_packet_flags;
    logic [7:0]        o_sequence_res;
    logic [15:0]       o_packet_crc;
    int                errors, pending, quiet_cycles;
    logic              no_idle = 1'b0;

    always #4 i_clk = ~i_clk;

    joystick_drive_shaper dut (.*);

    joystick_drive_shaper_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_raw_x, .i_raw_y, .i_send_now,
        .i_out_valid(o_out_valid), .i_out_stall, .i_speed(o_speed), .i_steer(o_steer),
        .i_sent(o_sent), .i_packet_flags(o_packet_flags), .i_sequence_res(o_sequence_res),
        .i_packet_crc(o_packet_crc), .o_errors(errors), .o_pending(pending)
    );

    // The watchdog only counts cycles in which no item moves on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Receiver stalls a random number of cycles ahead of each result.
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            n = no_idle ? 0 : $urandom_range(0, 6);
            if (n > 0) begin
                @(negedge i_clk);
                i_out_stall = 1'b1;
                repeat (n) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid || i_out_stall);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [11:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic push_sample(int rx, int ry, logic snd);
        int gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_raw_x = rx[11:0];
        i_raw_y = ry[11:0];
        i_send_now = snd;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    function automatic int axis_value(int centre);
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 4095);
            1:       return $urandom_range(0, 1) ? 0 : 4095;
            default: begin
                int v = centre + $urandom_range(0, 800) - 400;
                return v < 0 ? 0 : (v > 4095 ? 4095 : v);
            end
        endcase
    endfunction

    task automatic random_settings(int idx);
        int cx, cy;
        case (idx % 4)
            0: begin cx = 0; cy = 4095; end
            1: begin cx = 4095; cy = 0; end
            default: begin cx = $urandom_range(1500, 2600); cy = $urandom_range(1500, 2600); end
        endcase
        write_reg(jds_pkg::REG_CENTER_X, cx[11:0]);
        write_reg(jds_pkg::REG_CENTER_Y, cy[11:0]);
        case (idx % 5)
            0:       write_reg(jds_pkg::REG_DEADZONE, 12'd0);
            1:       write_reg(jds_pkg::REG_DEADZONE, 12'd2047);
            2:       write_reg(jds_pkg::REG_DEADZONE, 12'd2046);
            default: write_reg(jds_pkg::REG_DEADZONE, 12'($urandom_range(0, 400)));
        endcase
        write_reg(jds_pkg::REG_OPTIONS, 12'(idx % 8));
        write_reg(jds_pkg::REG_SPEED_MOD, 12'(idx % 4));
        write_reg(jds_pkg::REG_TURN_MODE, 12'((idx / 2) % 4));
        write_reg(jds_pkg::REG_RAMP_RATE, 12'((idx + 1) % 4));
    endtask

    initial begin
        int cx;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed items under the reset settings: centre, deadzone edges,
        // full-scale corners, and steps without a strobe.
        push_sample(2048, 2048, 1'b1);
        push_sample(2048 + 180, 2048 - 180, 1'b0);
        push_sample(2048 + 181, 2048 - 181, 1'b1);
        push_sample(0, 4095, 1'b1);
        push_sample(4095, 0, 1'b0);
        push_sample(4095, 4095, 1'b1);
        push_sample(0, 0, 1'b1);
        push_sample(12'hAAA, 12'h555, 1'b1);
        push_sample(12'h555, 12'hAAA, 1'b0);
        drain();

        // Every turn mode and the unused speed mode with a ramp, then a
        // deadzone wide enough to leave no span.
        write_reg(jds_pkg::REG_SPEED_MOD, 12'd3);
        write_reg(jds_pkg::REG_RAMP_RATE, 12'd3);
        for (int t = 0; t < 4; t++) begin
            write_reg(jds_pkg::REG_TURN_MODE, 12'(t));
            drain();
            push_sample(0, 4095, 1'b1);
            push_sample(4095, 0, 1'b1);
            push_sample(300, 3800, 1'b0);
            drain();
        end
        write_reg(jds_pkg::REG_DEADZONE, 12'd2047);
        write_reg(jds_pkg::REG_OPTIONS, 12'd3);
        write_reg(jds_pkg::REG_RAMP_RATE, 12'd0);
        push_sample(2048 + 2048, 2048 - 2048, 1'b1);
        push_sample(2048, 2047, 1'b1);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            random_settings(ph);
            no_idle = (ph % 3 == 2);
            cx = ph % 4 < 2 ? 2048 : 2048;
            for (int k = 0; k < 100; k++)
                push_sample(axis_value(cx), axis_value(cx), 1'($urandom_range(0, 1)));
            drain();
        end

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
